// ----- sv/combined_lcg_shuffle_random_macros.svh -----
// Assertion macros for the combined LCG shuffle generator.
// Used by the top level only; no other dependencies.
`ifndef COMBINED_LCG_SHUFFLE_RANDOM_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RANDOM_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CLSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define CLSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define CLSR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CLSR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/clsr_pkg.sv -----
// Package for the combined LCG shuffle generator: moduli, multipliers,
// Schrage constants, request kinds and reset values. No dependencies.
`default_nettype none
package clsr_pkg;
	localparam int TABLE_SIZE = 32;
	localparam logic [30:0] MOD1 = 31'd2147483563;
	localparam logic [30:0] MOD2 = 31'd2147483399;
	localparam logic [30:0] TOP1 = 31'd2147483562;
	localparam logic [15:0] MUL1 = 16'd40014;
	localparam logic [15:0] MUL2 = 16'd40692;
	localparam logic [15:0] QUO1 = 16'd53668;
	localparam logic [15:0] QUO2 = 16'd52774;
	localparam logic [30:0] VALUE_CLAMP = 31'd2147483305;
	localparam logic [30:0] SEED_RESET = 31'd348;
	localparam logic [30:0] GEN2_RESET = 31'd123456789;
	localparam logic [1:0] KIND_UNIFORM = 2'd0;
	localparam logic [1:0] KIND_FLIP = 2'd1;
	localparam logic [1:0] KIND_SCALED = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
endpackage
`default_nettype wire

// ----- sv/clsr_req_if.sv -----
// Request channel: valid/ready handshake with kind, bound, prob.
// No dependencies.
`default_nettype none
interface clsr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [30:0] bound;
	logic [32:0] prob;
	modport source (output valid, kind, bound, prob, input ready);
	modport sink (input valid, kind, bound, prob, output ready);
endinterface
`default_nettype wire

// ----- sv/clsr_rsp_if.sv -----
// Result channel: valid/ready handshake with value, flip, scaled.
// No dependencies.
`default_nettype none
interface clsr_rsp_if;
	logic        valid;
	logic        ready;
	logic [30:0] value;
	logic        flip;
	logic [30:0] scaled;
	modport source (output valid, value, flip, scaled, input ready);
	modport sink (input valid, value, flip, scaled, output ready);
endinterface
`default_nettype wire

// ----- sv/combined_lcg_shuffle_random.sv -----
// A seeded request runs a Schrage step on generator 1, then one on generator 2, then
// slot, table and flip (kind 2 adds the scaled product), all on one shared multiplier.
// The first request after reset or a seed write first runs TABLE_SIZE+8 seeding steps.
// One request at a time: ready only while idle, until the result has been taken.
// Reset (arst_n low, async): seed 348, generators 0 and 123456789, seeding pending.
// Depends on clsr_pkg, clsr_req_if, clsr_rsp_if and the assertion macro header.
`default_nettype none
`include "combined_lcg_shuffle_random_macros.svh"
module combined_lcg_shuffle_random #(
	parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [30:0] seed_wdata,
	clsr_req_if.sink         request,
	clsr_rsp_if.source       result
);
	localparam int IW = $clog2(TABLE_SIZE);
	localparam int JW = $clog2(TABLE_SIZE + 8);
	localparam logic [30:0] SLOT_DIV = 31'(1 + 2147483562 / TABLE_SIZE);
	// reciprocals: floor(x/d) = (x*ceil(2^s/d)) >> s for any 31-bit x
	localparam int QSH1 = 31 + $clog2(int'(clsr_pkg::QUO1));
	localparam int QSH2 = 31 + $clog2(int'(clsr_pkg::QUO2));
	localparam int SLOT_SH = 31 + $clog2(int'(SLOT_DIV));
	localparam logic [31:0] RCP1 = 32'(((64'd1 << QSH1) + 64'(clsr_pkg::QUO1) - 64'd1)
		/ 64'(clsr_pkg::QUO1));
	localparam logic [31:0] RCP2 = 32'(((64'd1 << QSH2) + 64'(clsr_pkg::QUO2) - 64'd1)
		/ 64'(clsr_pkg::QUO2));
	localparam logic [31:0] SLOT_RCP = 32'(((64'd1 << SLOT_SH) + 64'(SLOT_DIV) - 64'd1)
		/ 64'(SLOT_DIV));
	// 2^31 mod MOD1, used to fold the scaled product
	localparam logic [6:0] MOD1_GAP = 7'(32'h8000_0000 - 32'(clsr_pkg::MOD1));

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCH_RCP, ST_SCH_MUL1, ST_SCH_MUL2, ST_SCH_FIN,
		ST_SLOT_RCP, ST_SLOT_SAT, ST_TBL_RD, ST_TBL_UPD, ST_FLIP_MUL,
		ST_FLIP_CMP, ST_SCL_MUL, ST_SCL_F1, ST_SCL_F2, ST_OUT
	} state_t;
	typedef enum logic [1:0] {SEL_SEED, SEL_G1, SEL_G2} sel_t;

	state_t        state_q;
	sel_t          sel_q;
	logic [30:0]   seed_q, gen1_q, gen2_q, shuf_q;
	logic          seeded_q;
	logic [JW-1:0] j_q;
	logic [IW-1:0] slot_q;
	logic [1:0]    kind_q;
	logic [30:0]   bound_q;
	logic [32:0]   prob_q;
	logic [30:0]   val_q, scaled_q;
	logic          flip_q;
	logic [15:0]   k_q;
	logic [30:0]   qacc_q;
	// shared multiplier
	logic [62:0]   prod_q;
	logic [46:0]   p1_q;
	logic [30:0]   rd_q;
	logic [30:0]   tbl_mem [TABLE_SIZE];

	// multiplier operand select
	logic [31:0] mul_a;
	logic [30:0] mul_b;
	logic [62:0] mul_p;
	always_comb begin
		case (state_q)
			ST_SCH_RCP: begin
				mul_a = (sel_q == SEL_G2) ? RCP2 : RCP1;
				mul_b = (sel_q == SEL_G2) ? gen2_q : gen1_q;
			end
			ST_SCH_MUL1: begin
				mul_a = {16'd0, (sel_q == SEL_G2) ? clsr_pkg::MUL2 : clsr_pkg::MUL1};
				mul_b = (sel_q == SEL_G2) ? gen2_q : gen1_q;
			end
			ST_SCH_MUL2: begin
				mul_a = {16'd0, k_q};
				mul_b = (sel_q == SEL_G2) ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
			end
			ST_SLOT_RCP: begin
				mul_a = SLOT_RCP;
				mul_b = shuf_q;
			end
			ST_FLIP_MUL: begin
				mul_a = prob_q[31:0];
				mul_b = clsr_pkg::MOD1;
			end
			ST_SCL_MUL: begin
				mul_a = {1'b0, val_q};
				mul_b = bound_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = {31'd0, mul_a} * {32'd0, mul_b};
	end

	// Schrage result: mul*x - k*mod, folded once
	logic [47:0] sch_diff, sch_fold;
	logic [30:0] sch_res;
	always_comb begin
		sch_diff = {1'b0, p1_q} - {1'b0, prod_q[46:0]};
		sch_fold = sch_diff + {17'd0,
			(sel_q == SEL_G2) ? clsr_pkg::MOD2 : clsr_pkg::MOD1};
		sch_res = sch_diff[47] ? sch_fold[30:0] : sch_diff[30:0];
	end

	// slot quotient from the reciprocal product
	logic [62:0] slot_quo;
	assign slot_quo = prod_q >> SLOT_SH;

	// scaled quotient: P = H*2^31 + L = H*MOD1 + (H*GAP + L), folded twice
	logic [37:0] fold1;
	logic [31:0] fold2, fold_q;
	always_comb begin
		fold1 = {7'd0, prod_q[61:31]} * {31'd0, MOD1_GAP} + {7'd0, prod_q[30:0]};
		fold2 = {25'd0, prod_q[37:31]} * {25'd0, MOD1_GAP} + {1'b0, prod_q[30:0]};
		fold_q = {1'b0, qacc_q} + {25'd0, prod_q[37:31]}
			+ ((fold2 >= {1'b0, clsr_pkg::MOD1}) ? 32'd1 : 32'd0);
	end

	// table combine
	logic [32:0] tbl_diff, tbl_fold;
	logic [30:0] tbl_y;
	always_comb begin
		tbl_diff = {2'b0, rd_q} - {2'b0, gen2_q};
		tbl_fold = tbl_diff + {2'b0, clsr_pkg::TOP1};
		tbl_y = (tbl_diff[32] || tbl_diff == '0) ? tbl_fold[30:0] : tbl_diff[30:0];
	end

	// table write port
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [30:0]   mem_wd;
	always_comb begin
		mem_we = (state_q == ST_TBL_UPD) || (state_q == ST_SCH_FIN
			&& sel_q == SEL_SEED && j_q < JW'(TABLE_SIZE));
		mem_wa = (state_q == ST_TBL_UPD) ? slot_q : j_q[IW-1:0];
		mem_wd = (state_q == ST_TBL_UPD) ? gen1_q : sch_res;
	end

	// shuffle table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_wa] <= mem_wd;
		end
		rd_q <= tbl_mem[slot_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sel_q    <= SEL_SEED;
			seed_q   <= clsr_pkg::SEED_RESET;
			gen1_q   <= '0;
			gen2_q   <= clsr_pkg::GEN2_RESET;
			shuf_q   <= '0;
			seeded_q <= 1'b0;
			j_q      <= '0;
			slot_q   <= '0;
			kind_q   <= '0;
			bound_q  <= '0;
			prob_q   <= '0;
			val_q    <= '0;
			scaled_q <= '0;
			flip_q   <= 1'b0;
			k_q      <= '0;
			qacc_q   <= '0;
			prod_q   <= '0;
			p1_q     <= '0;
		end else begin
			if (seed_we) begin
				seed_q   <= seed_wdata;
				seeded_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (request.valid) begin
						kind_q  <= request.kind;
						bound_q <= request.bound;
						prob_q  <= request.prob;
						state_q <= ST_SCH_RCP;
						if (!seeded_q) begin
							gen1_q <= (seed_q == '0) ? 31'd1 : seed_q;
							gen2_q <= (seed_q == '0) ? 31'd1 : seed_q;
							j_q    <= JW'(TABLE_SIZE + 7);
							sel_q  <= SEL_SEED;
						end else begin
							sel_q <= SEL_G1;
						end
					end
				end
				ST_SCH_RCP: begin
					prod_q  <= mul_p;
					state_q <= ST_SCH_MUL1;
				end
				ST_SCH_MUL1: begin
					k_q     <= (sel_q == SEL_G2) ? 16'(prod_q >> QSH2) : 16'(prod_q >> QSH1);
					prod_q  <= mul_p;
					state_q <= ST_SCH_MUL2;
				end
				ST_SCH_MUL2: begin
					p1_q    <= prod_q[46:0];
					prod_q  <= mul_p;
					state_q <= ST_SCH_FIN;
				end
				ST_SCH_FIN: begin
					state_q <= ST_SCH_RCP;
					case (sel_q)
						SEL_SEED: begin
							gen1_q <= sch_res;
							if (j_q == '0) begin
								shuf_q   <= sch_res;
								seeded_q <= 1'b1;
								sel_q    <= SEL_G1;
							end else begin
								j_q <= j_q - JW'(1);
							end
						end
						SEL_G1: begin
							gen1_q <= sch_res;
							sel_q  <= SEL_G2;
						end
						default: begin
							gen2_q  <= sch_res;
							state_q <= ST_SLOT_RCP;
						end
					endcase
				end
				ST_SLOT_RCP: begin
					prod_q  <= mul_p;
					state_q <= ST_SLOT_SAT;
				end
				ST_SLOT_SAT: begin
					slot_q  <= (slot_quo >= 63'(TABLE_SIZE)) ?
						IW'(TABLE_SIZE - 1) : slot_quo[IW-1:0];
					state_q <= ST_TBL_RD;
				end
				ST_TBL_RD: begin
					state_q <= ST_TBL_UPD;
				end
				ST_TBL_UPD: begin
					shuf_q  <= tbl_y;
					val_q   <= (tbl_y > clsr_pkg::VALUE_CLAMP) ?
						clsr_pkg::VALUE_CLAMP : tbl_y;
					state_q <= ST_FLIP_MUL;
				end
				ST_FLIP_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_FLIP_CMP;
				end
				ST_FLIP_CMP: begin
					flip_q   <= prob_q[32] || ({val_q, 32'd0} <= prod_q);
					scaled_q <= '0;
					state_q  <= (kind_q == clsr_pkg::KIND_SCALED) ? ST_SCL_MUL : ST_OUT;
				end
				ST_SCL_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_SCL_F1;
				end
				ST_SCL_F1: begin
					qacc_q  <= prod_q[61:31];
					prod_q  <= {25'd0, fold1};
					state_q <= ST_SCL_F2;
				end
				ST_SCL_F2: begin
					scaled_q <= fold_q[30:0];
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign request.ready = (state_q == ST_IDLE);
	assign result.valid  = (state_q == ST_OUT);
	assign result.value  = val_q;
	assign result.flip   = flip_q;
	assign result.scaled = scaled_q;

	// checks
	`CLSR_ASSERT_IMP(a_no_overlap, clk, arst_n, result.valid, !request.ready)
	`CLSR_ASSERT_NXT(a_busy_after_req, clk, arst_n, request.valid && request.ready, !request.ready)
	`CLSR_ASSERT_NXT(a_seed_rearm, clk, arst_n, seed_we, !seeded_q || state_q != ST_IDLE)
	`CLSR_ASSERT_IMP(a_slot_range, clk, arst_n, state_q == ST_TBL_RD, slot_q <= IW'(TABLE_SIZE - 1))
endmodule
`default_nettype wire

// ----- verif/combined_lcg_shuffle_random_check.sv -----
`timescale 1ns / 100ps
// Checker for the combined LCG shuffle generator: watches the request and result
// channels and the seed port, predicts each result and compares it field by field.
// Depends on clsr_pkg, clsr_req_if and clsr_rsp_if.
`default_nettype none
module combined_lcg_shuffle_random_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [30:0] seed_wdata,
	clsr_req_if              request,
	clsr_rsp_if              result,
	output int               errors,
	output int               pending,
	output int               received
);
	typedef struct packed {
		logic [30:0] value;
		logic        flip;
		logic [30:0] scaled;
	} draw_t;

	localparam longint SLOT_DIV = 1 + longint'(clsr_pkg::TOP1) / clsr_pkg::TABLE_SIZE;

	logic [30:0] seed_reg;
	longint      gen1, gen2, shuf_out;
	longint      shuf_tab [clsr_pkg::TABLE_SIZE];
	bit          armed;
	draw_t       draws_due [$];

	function automatic longint schrage_step(longint x, longint mul, longint quo,
			longint modulus);
		longint k;
		longint rem;
		longint y;
		rem = modulus % mul;
		k = x / quo;
		y = mul * (x - k * quo) - k * rem;
		if (y < 0) y += modulus;
		return y & 64'h7FFF_FFFF;
	endfunction

	// advance the generator and work out the next draw
	function automatic draw_t next_draw(logic [1:0] kind, logic [30:0] bound,
			logic [32:0] prob);
		draw_t  d;
		longint g;
		longint slot;
		longint y;
		longint unsigned v;
		longint unsigned p;
		if (!armed) begin
			g = (seed_reg == 0) ? 1 : longint'(seed_reg);
			gen2 = g;
			for (int j = clsr_pkg::TABLE_SIZE + 7; j >= 0; j--) begin
				g = schrage_step(g, clsr_pkg::MUL1, clsr_pkg::QUO1, clsr_pkg::MOD1);
				if (j < clsr_pkg::TABLE_SIZE) shuf_tab[j] = g;
			end
			gen1 = g;
			shuf_out = shuf_tab[0];
			armed = 1;
		end
		gen1 = schrage_step(gen1, clsr_pkg::MUL1, clsr_pkg::QUO1, clsr_pkg::MOD1);
		gen2 = schrage_step(gen2, clsr_pkg::MUL2, clsr_pkg::QUO2, clsr_pkg::MOD2);
		slot = shuf_out / SLOT_DIV;
		if (slot >= clsr_pkg::TABLE_SIZE) slot = clsr_pkg::TABLE_SIZE - 1;
		y = shuf_tab[slot] - gen2;
		shuf_tab[slot] = gen1;
		if (y < 1) y += clsr_pkg::TOP1;
		shuf_out = y & 64'h7FFF_FFFF;
		v = shuf_out;
		if (v > clsr_pkg::VALUE_CLAMP) v = clsr_pkg::VALUE_CLAMP;
		p = prob;
		if (p > 64'h1_0000_0000) p = 64'h1_0000_0000;
		d.value = v[30:0];
		d.flip = ((v << 32) <= p * longint'(clsr_pkg::MOD1));
		d.scaled = (kind == clsr_pkg::KIND_SCALED) ?
			31'((v * bound) / longint'(clsr_pkg::MOD1)) : '0;
		return d;
	endfunction

	assign pending = draws_due.size();

	always @(posedge clk or negedge arst_n) begin
		draw_t want;
		draw_t got;
		if (!arst_n) begin
			seed_reg <= clsr_pkg::SEED_RESET;
			gen1 = 0;
			gen2 = clsr_pkg::GEN2_RESET;
			shuf_out = 0;
			armed = 0;
			draws_due.delete();
			errors <= 0;
			received <= 0;
		end else begin
			if (seed_we) begin
				seed_reg <= seed_wdata;
				armed = 0;
			end
			if (request.valid && request.ready)
				draws_due.push_back(next_draw(request.kind, request.bound, request.prob));
			// compare result with the oldest prediction
			if (result.valid && result.ready) begin
				got = '{result.value, result.flip, result.scaled};
				received <= received + 1;
				if (draws_due.size() == 0) begin
					$display("%t: unexpected result value=%0d flip=%0d scaled=%0d",
						$time, got.value, got.flip, got.scaled);
					errors <= errors + 1;
				end else begin
					want = draws_due.pop_front();
					if (want != got) begin
						$display("%t: mismatch expected value=%0d flip=%0d scaled=%0d",
							$time, want.value, want.flip, want.scaled);
						$display("%t:          actual   value=%0d flip=%0d scaled=%0d",
							$time, got.value, got.flip, got.scaled);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- verif/combined_lcg_shuffle_random_test.sv -----
`timescale 1ns / 100ps
// Top of the generator testbench: clock, reset, seed writes and request stimulus.
// Depends on the block, its package and interfaces, and the checker module.
`default_nettype none
module combined_lcg_shuffle_random_test;
	logic        clk;
	logic        arst_n;
	logic        seed_we;
	logic [30:0] seed_wdata;
	int          errors, pending, received;
	int          sent;

	clsr_req_if request ();
	clsr_rsp_if result ();

	combined_lcg_shuffle_random dut (
		.clk(clk), .arst_n(arst_n), .seed_we(seed_we), .seed_wdata(seed_wdata),
		.request(request), .result(result)
	);

	combined_lcg_shuffle_random_check checker_u (
		.clk(clk), .arst_n(arst_n), .seed_we(seed_we), .seed_wdata(seed_wdata),
		.request(request), .result(result),
		.errors(errors), .pending(pending), .received(received)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver stalls drawn per result
	initial begin
		int stall;
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 5);
			repeat (stall) @(posedge clk);
			result.ready <= 1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
			result.ready <= 0;
		end
	end

	// drive one request and drop valid after acceptance
	task automatic send_request(logic [1:0] kind, logic [30:0] bound, logic [32:0] prob);
		request.valid <= 1;
		request.kind <= kind;
		request.bound <= bound;
		request.prob <= prob;
		@(posedge clk);
		while (!request.ready) @(posedge clk);
		request.valid <= 0;
		sent++;
		@(posedge clk);
	endtask

	task automatic send_gapped(logic [1:0] kind, logic [30:0] bound, logic [32:0] prob);
		repeat ($urandom_range(0, 5)) @(posedge clk);
		send_request(kind, bound, prob);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_seed(logic [30:0] s);
		seed_we <= 1;
		seed_wdata <= s;
		@(posedge clk);
		seed_we <= 0;
	endtask

	function automatic logic [32:0] rand_prob();
		case ($urandom_range(0, 3))
			0: return {1'b0, $urandom()};
			1: return {1'b1, 32'($urandom_range(0, 1) ? $urandom() : 0)};
			default: return {1'b0, $urandom()};
		endcase
	endfunction

	initial begin
		logic [30:0] seeds [6] = '{31'd0, 31'd1, 31'd2147483562, 31'h7FFF_FFFF,
			31'd12345, 31'd2147483563};
		sent = 0;
		arst_n = 0;
		seed_we = 0;
		seed_wdata = '0;
		request.valid = 0;
		request.kind = '0;
		request.bound = '0;
		request.prob = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset seed, every kind, field extremes and over-one probability
		send_request(clsr_pkg::KIND_UNIFORM, '0, '0);
		send_request(clsr_pkg::KIND_FLIP, '0, 33'h1_0000_0000);
		send_request(clsr_pkg::KIND_SCALED, 31'h7FFF_FFFF, 33'h1_FFFF_FFFF);
		send_request(clsr_pkg::KIND_SPARE, 31'h7FFF_FFFF, 33'h0_FFFF_FFFF);
		send_request(clsr_pkg::KIND_SCALED, '0, 33'h1_0000_0001);
		send_request(clsr_pkg::KIND_SCALED, 31'd1, 33'h0_8000_0000);
		send_request(clsr_pkg::KIND_FLIP, 31'h5555_5555, 33'h0_0000_0001);
		send_request(clsr_pkg::KIND_SCALED, 31'h2AAA_AAAA, 33'h1_5555_5555);
		drain();

		// random phases under several seeds, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			write_seed(seeds[ph]);
			for (int i = 0; i < 74; i++) begin
				send_gapped(2'($urandom_range(0, 3)),
					$urandom_range(0, 1) ? 31'($urandom()) : 31'($urandom_range(0, 9)),
					rand_prob());
				if (i == 37) drain();
			end
			drain();
		end

		$display("Covered %0d requests, %0d results checked, over seven seeds incl. extremes.",
			sent, received);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#60ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
